// ----- rtl/core/bde_pkg.sv -----
// ----------------------------------------------------------------------------
// bde_pkg
// shared sizes and command codes of the bounded deque engine
// ----------------------------------------------------------------------------
package bde_pkg;

	localparam int DEPTH  = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	// count also serves as the ascending value counter, which can reach depth plus one
	localparam int CNT_W  = $clog2(DEPTH + 2);
	localparam int DATA_W = 32;
	localparam int N_W    = DATA_W - 1;
	localparam int CMD_W  = 4;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 4'd0;
	localparam logic [CMD_W-1:0] CMD_INS_BACK   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_RM_FRONT   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_RM_BACK    = 4'd3;
	localparam logic [CMD_W-1:0] CMD_RM_LAST_N  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_RM_SECOND  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_APPEND_SZ  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_APPEND_ASC = 4'd7;
	localparam logic [CMD_W-1:0] CMD_INS_PENULT = 4'd8;
	localparam logic [CMD_W-1:0] CMD_DUMP       = 4'd9;

endpackage

// ----- rtl/core/bde_ram.sv -----
// ----------------------------------------------------------------------------
// bde_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bde_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/bounded_deque_engine.sv -----
// plain end commands pass through the status state into the output register;
// remove second adds the ram read state; insert penultimate adds ram read, then the second write
// ascending append writes one value per cycle, at most DEPTH values
// dump reads each entry from the ram, then waits for a free output register; one item in flight at a time
// reset: async, active low; list becomes empty, the ram is not cleared and needs no sweep
// ----------------------------------------------------------------------------
// bounded_deque_engine
// bounded deque of signed words in a ring buffer ram with head index and count
// ----------------------------------------------------------------------------
module bounded_deque_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	// command side
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bde_pkg::CMD_W-1:0]   cmd,
	input  logic signed [31:0]          operand,
	// result side
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          item_value,
	output logic                        item_valid,
	output logic                        last_of_run,
	output logic [bde_pkg::CNT_W-1:0]   list_size,
	output logic                        list_empty,
	output logic                        overflow
);

	localparam int CNT_W  = bde_pkg::CNT_W;
	localparam int IDX_W  = bde_pkg::IDX_W;
	localparam int DATA_W = bde_pkg::DATA_W;
	localparam int N_W    = bde_pkg::N_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(bde_pkg::DEPTH);
	localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W+1)'(bde_pkg::DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,        // ram read data for rm_second / ins_penult arrives
		ST_WR2,       // ins_penult: new value goes into the old last slot
		ST_ASC,       // ascending append, one value per cycle
		ST_DUMP_RD,   // issue read of the next entry
		ST_DUMP_WAIT, // entry data ready, wait for a free output register
		ST_RESP       // single status beat
	} state_t;

	// ring position of the k-th entry from the front
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] k);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + {1'b0, k};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[IDX_W-1:0];
	endfunction

	state_t                  state_q;
	logic [IDX_W-1:0]        head_q;
	logic [CNT_W-1:0]        count_q;
	logic                    ovf_q;
	logic [bde_pkg::CMD_W-1:0] cmd_q;
	logic [DATA_W-1:0]       opnd_q;
	logic [N_W-1:0]          n_q;
	logic [CNT_W-1:0]        i_q;

	logic                    out_valid_q;
	logic [DATA_W-1:0]       item_value_q;
	logic                    item_valid_q;
	logic                    last_q;
	logic [CNT_W-1:0]        size_q;
	logic                    empty_q;
	logic                    ovf_out_q;

	// ram port signals
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [DATA_W-1:0]       ram_wdata;
	logic                    ram_re;
	logic [IDX_W-1:0]        ram_raddr;
	logic [DATA_W-1:0]       ram_rdata;

	logic                    accept;
	logic                    full;
	logic                    two_plus;
	logic                    out_free;
	logic                    out_load;
	logic                    ins_drop;
	logic [N_W-1:0]          n_in;
	logic [IDX_W-1:0]        head_dec;
	logic [CNT_W-1:0]        count_dec;
	logic                    asc_le;
	logic                    asc_go;
	logic [CNT_W-1:0]        i_inc;
	logic                    dump_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == FULL_CNT);
	assign two_plus  = (count_q >= CNT_W'(2));
	// output register can take a new beat when empty or being drained this cycle
	assign out_free  = !out_valid_q || out_ready;
	// a status or dump beat goes into the output register this cycle
	assign out_load  = out_free && ((state_q == ST_RESP) || (state_q == ST_DUMP_WAIT));
	// single inserts that find the list full are dropped
	assign ins_drop  = full && ((cmd == bde_pkg::CMD_INS_FRONT) ||
		(cmd == bde_pkg::CMD_INS_BACK) || (cmd == bde_pkg::CMD_APPEND_SZ) ||
		((cmd == bde_pkg::CMD_INS_PENULT) && two_plus));
	// negative count means zero
	assign n_in      = operand[DATA_W-1] ? '0 : operand[N_W-1:0];
	assign head_dec  = (head_q == '0) ? IDX_W'(bde_pkg::DEPTH - 1) : head_q - 1'b1;
	assign count_dec = count_q - 1'b1;
	assign asc_le    = (N_W'(i_q) <= n_q);
	assign asc_go    = asc_le && !full;
	assign i_inc     = i_q + 1'b1;
	assign dump_last = (i_inc == count_q);

	// ram access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (cmd)
						bde_pkg::CMD_INS_FRONT: begin
							ram_we    = !full;
							ram_waddr = head_dec;
							ram_wdata = operand;
						end
						bde_pkg::CMD_INS_BACK: begin
							ram_we    = !full;
							ram_waddr = slot(head_q, count_q);
							ram_wdata = operand;
						end
						bde_pkg::CMD_APPEND_SZ: begin
							ram_we    = !full;
							ram_waddr = slot(head_q, count_q);
							ram_wdata = DATA_W'(count_q);
						end
						bde_pkg::CMD_RM_SECOND: begin
							ram_re    = two_plus;
							ram_raddr = head_q;
						end
						bde_pkg::CMD_INS_PENULT: begin
							ram_re    = two_plus && !full;
							ram_raddr = slot(head_q, count_dec);
						end
						default: begin
						end
					endcase
				end
			end
			ST_RD: begin
				// rm_second copies the front into slot one; ins_penult moves the last up
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				if (cmd_q == bde_pkg::CMD_RM_SECOND) begin
					ram_waddr = slot(head_q, CNT_W'(1));
				end else begin
					ram_waddr = slot(head_q, count_q);
				end
			end
			ST_WR2: begin
				ram_we    = 1'b1;
				ram_waddr = slot(head_q, count_dec);
				ram_wdata = opnd_q;
			end
			ST_ASC: begin
				ram_we    = asc_go;
				ram_waddr = slot(head_q, count_q);
				ram_wdata = DATA_W'(i_q);
			end
			ST_DUMP_RD: begin
				ram_re    = 1'b1;
				ram_raddr = slot(head_q, i_q);
			end
			default: begin
			end
		endcase
	end

	bde_ram #(
		.DATA_W (DATA_W),
		.DEPTH  (bde_pkg::DEPTH),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// state, list pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			cmd_q        <= '0;
			opnd_q       <= '0;
			n_q          <= '0;
			i_q          <= '0;
			out_valid_q  <= 1'b0;
			item_value_q <= '0;
			item_valid_q <= 1'b0;
			last_q       <= 1'b0;
			size_q       <= '0;
			empty_q      <= 1'b1;
			ovf_out_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q  <= cmd;
						opnd_q <= operand;
						ovf_q  <= ins_drop;
						case (cmd)
							bde_pkg::CMD_INS_FRONT: begin
								if (!full) begin
									head_q  <= head_dec;
									count_q <= count_q + 1'b1;
								end
								state_q <= ST_RESP;
							end
							bde_pkg::CMD_INS_BACK, bde_pkg::CMD_APPEND_SZ: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= ST_RESP;
							end
							bde_pkg::CMD_RM_FRONT: begin
								if (count_q != '0) begin
									head_q  <= slot(head_q, CNT_W'(1));
									count_q <= count_dec;
								end
								state_q <= ST_RESP;
							end
							bde_pkg::CMD_RM_BACK: begin
								if (count_q != '0) begin
									count_q <= count_dec;
								end
								state_q <= ST_RESP;
							end
							bde_pkg::CMD_RM_LAST_N: begin
								if (n_in >= N_W'(count_q)) begin
									count_q <= '0;
								end else begin
									count_q <= count_q - n_in[CNT_W-1:0];
								end
								state_q <= ST_RESP;
							end
							bde_pkg::CMD_RM_SECOND: begin
								state_q <= two_plus ? ST_RD : ST_RESP;
							end
							bde_pkg::CMD_APPEND_ASC: begin
								n_q     <= n_in;
								i_q     <= CNT_W'(1);
								state_q <= ST_ASC;
							end
							bde_pkg::CMD_INS_PENULT: begin
								// full list drops the value, short list does nothing
								state_q <= (two_plus && !full) ? ST_RD : ST_RESP;
							end
							bde_pkg::CMD_DUMP: begin
								i_q     <= '0;
								state_q <= (count_q != '0) ? ST_DUMP_RD : ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_RD: begin
					if (cmd_q == bde_pkg::CMD_RM_SECOND) begin
						head_q  <= slot(head_q, CNT_W'(1));
						count_q <= count_dec;
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_WR2;
					end
				end
				ST_WR2: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_RESP;
				end
				ST_ASC: begin
					if (asc_go) begin
						count_q <= count_q + 1'b1;
						i_q     <= i_inc;
					end else begin
						// values left over means the store filled up
						ovf_q   <= asc_le;
						state_q <= ST_RESP;
					end
				end
				ST_DUMP_RD: begin
					state_q <= ST_DUMP_WAIT;
				end
				ST_DUMP_WAIT: begin
					if (out_free) begin
						item_value_q <= ram_rdata;
						item_valid_q <= 1'b1;
						last_q       <= dump_last;
						size_q       <= count_q;
						empty_q      <= 1'b0;
						ovf_out_q    <= 1'b0;
						i_q          <= i_inc;
						state_q      <= dump_last ? ST_IDLE : ST_DUMP_RD;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						item_value_q <= '0;
						item_valid_q <= 1'b0;
						last_q       <= 1'b1;
						size_q       <= count_q;
						empty_q      <= (count_q == '0);
						ovf_out_q    <= ovf_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign item_value  = item_value_q;
	assign item_valid  = item_valid_q;
	assign last_of_run = last_q;
	assign list_size   = size_q;
	assign list_empty  = empty_q;
	assign overflow    = ovf_out_q;

	// list never grows past the ring size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond depth");

	// one ram access per cycle in this sequencer
	a_ram_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ram read and write in the same cycle");

	// a dropped insert only happens with a full list
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ovf_out_q |-> size_q == FULL_CNT)
		else $error("overflow reported on a list that is not full");

	// a dumped entry comes from a non-empty list and carries no overflow
	a_dump_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && item_valid_q |-> !empty_q && !ovf_out_q)
		else $error("dump beat with empty list or overflow");

endmodule

// ----- test/bde_checker.sv -----
// ----------------------------------------------------------------------------
// bde_checker
// watches both channels of the deque engine, keeps its own copy of the list
// and compares every result beat with the predicted one
// ----------------------------------------------------------------------------
module bde_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [bde_pkg::CMD_W-1:0]         cmd,
	input  logic signed [bde_pkg::DATA_W-1:0] operand,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [bde_pkg::DATA_W-1:0] item_value,
	input  logic                              item_valid,
	input  logic                              last_of_run,
	input  logic [bde_pkg::CNT_W-1:0]         list_size,
	input  logic                              list_empty,
	input  logic                              overflow,
	output int                                mismatches,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH  = bde_pkg::DEPTH;
	localparam int DATA_W = bde_pkg::DATA_W;
	localparam int CNT_W  = bde_pkg::CNT_W;
	localparam int CMD_W  = bde_pkg::CMD_W;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     valid;
		logic                     last;
		logic [CNT_W-1:0]         size;
		logic                     empty;
		logic                     ovf;
	} deque_beat_t;

	deque_beat_t              expected_beats[$];
	logic signed [DATA_W-1:0] ring [DEPTH];
	int                       head;
	int                       count;
	int                       error_count = 0;

	task automatic report_error(input string what);
		$display("[%0t] deque check: %s", $time, what);
		error_count++;
	endtask

	function automatic int slot_of(input int k);
		return (head + k) % DEPTH;
	endfunction

	function automatic bit store_at_back(input logic signed [DATA_W-1:0] word);
		if (count >= DEPTH)
			return 1'b0;
		ring[slot_of(count)] = word;
		count++;
		return 1'b1;
	endfunction

	task automatic push_beat(input logic signed [DATA_W-1:0] value, input logic valid,
			input logic last, input logic ovf);
		deque_beat_t b;
		b.value = value;
		b.valid = valid;
		b.last  = last;
		b.size  = CNT_W'(count);
		b.empty = (count == 0);
		b.ovf   = ovf;
		expected_beats.push_back(b);
	endtask

	// apply one command to the shadow list and queue the beats it gives
	task automatic predict_cmd(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] arg);
		int   n;
		int   i;
		int   tail;
		logic ovf;
		n   = arg[DATA_W-1] ? 0 : int'(arg);
		ovf = 1'b0;
		case (c)
			bde_pkg::CMD_INS_FRONT: begin
				if (count >= DEPTH) begin
					ovf = 1'b1;
				end else begin
					head       = (head + DEPTH - 1) % DEPTH;
					ring[head] = arg;
					count++;
				end
			end
			bde_pkg::CMD_INS_BACK: ovf = !store_at_back(arg);
			bde_pkg::CMD_RM_FRONT: begin
				if (count > 0) begin
					head = slot_of(1);
					count--;
				end
			end
			bde_pkg::CMD_RM_BACK: begin
				if (count > 0)
					count--;
			end
			bde_pkg::CMD_RM_LAST_N: count = (n >= count) ? 0 : count - n;
			bde_pkg::CMD_RM_SECOND: begin
				if (count >= 2) begin
					ring[slot_of(1)] = ring[slot_of(0)];
					head = slot_of(1);
					count--;
				end
			end
			bde_pkg::CMD_APPEND_SZ: ovf = !store_at_back(DATA_W'(count));
			bde_pkg::CMD_APPEND_ASC: begin
				i = 1;
				while (i <= n && count < DEPTH) begin
					void'(store_at_back(DATA_W'(i)));
					i++;
				end
				ovf = (i <= n);
			end
			bde_pkg::CMD_INS_PENULT: begin
				if (count >= 2) begin
					if (count >= DEPTH) begin
						ovf = 1'b1;
					end else begin
						tail = slot_of(count - 1);
						ring[slot_of(count)] = ring[tail];
						ring[tail] = arg;
						count++;
					end
				end
			end
			default: ;
		endcase
		if (c == bde_pkg::CMD_DUMP && count != 0) begin
			for (i = 0; i < count; i++)
				push_beat(ring[slot_of(i)], 1'b1, i == count - 1, 1'b0);
		end else begin
			push_beat('0, 1'b0, 1'b1, ovf);
		end
	endtask

	task automatic check_beat();
		deque_beat_t want;
		if (expected_beats.size() == 0) begin
			report_error("result beat with nothing expected");
			return;
		end
		want = expected_beats.pop_front();
		if (item_value !== want.value)
			report_error($sformatf("item_value got %0d want %0d", item_value, want.value));
		if (item_valid !== want.valid)
			report_error($sformatf("item_valid got %b want %b", item_valid, want.valid));
		if (last_of_run !== want.last)
			report_error($sformatf("last_of_run got %b want %b", last_of_run, want.last));
		if (list_size !== want.size)
			report_error($sformatf("list_size got %0d want %0d", list_size, want.size));
		if (list_empty !== want.empty)
			report_error($sformatf("list_empty got %b want %b", list_empty, want.empty));
		if (overflow !== want.ovf)
			report_error($sformatf("overflow got %b want %b", overflow, want.ovf));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head  = 0;
			count = 0;
			expected_beats.delete();
			pending    <= 0;
			mismatches <= error_count;
		end else begin
			if (in_valid && in_ready)
				predict_cmd(cmd, operand);
			if (out_valid && out_ready)
				check_beat();
			pending    <= expected_beats.size();
			mismatches <= error_count;
		end
	end

endmodule

// ----- test/bounded_deque_engine_tb.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_engine_tb
// drives command beats into the deque engine with random gaps and result
// stalls; a checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module bounded_deque_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CMD_W  = bde_pkg::CMD_W;
	localparam int DATA_W = bde_pkg::DATA_W;
	localparam int CNT_W  = bde_pkg::CNT_W;

	// codes with no operation behind them
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

	localparam int RANDOM_ITEMS     = 96;
	localparam int CALM_ITEMS       = 20;   // final stretch with no idling at all
	localparam int HOLD_AT_ITEM     = 10;   // where the long result stall starts
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int DRAIN_LIMIT      = 20000;
	localparam int SETTLE_CYCLES    = 16;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] operand;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] item_value;
	logic                     item_valid;
	logic                     last_of_run;
	logic [CNT_W-1:0]         list_size;
	logic                     list_empty;
	logic                     overflow;
	int                       mismatches;
	int                       pending;

	// stimulus asks the result side for one long stall, and later for calm
	logic hold_request;
	logic calm;

	bounded_deque_engine uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.operand     (operand),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.item_value  (item_value),
		.item_valid  (item_valid),
		.last_of_run (last_of_run),
		.list_size   (list_size),
		.list_empty  (list_empty),
		.overflow    (overflow)
	);

	bde_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.operand     (operand),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.item_value  (item_value),
		.item_valid  (item_valid),
		.last_of_run (last_of_run),
		.list_size   (list_size),
		.list_empty  (list_empty),
		.overflow    (overflow),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	// result side: short random stall bursts, one long stall on request,
	// always ready once the run has gone calm
	initial begin
		bit long_done;
		long_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !long_done) begin
				// long stall so the engine backs up and stops taking commands
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
				long_done = 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// offer one command beat, maybe after an idle burst, and hold it until taken
	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] arg);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		operand  <= arg;
		do @(posedge clk); while (!in_ready);
	endtask

	// insert values lean on the extremes now and then
	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return -1;
			3:       return 0;
			default: return $urandom();
		endcase
	endfunction

	// counts for remove last n and ascending append: mostly small,
	// sometimes past the depth, huge or negative
	function automatic logic signed [DATA_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(0, 6);
		else if (r < 17)
			return $urandom_range(7, 40);
		else if (r == 17)
			return 32'h7fff_ffff;
		else if (r == 18)
			return $urandom() | 32'h8000_0000;
		else
			return 0;
	endfunction

	// random pick among the codes that do nothing
	function automatic logic [CMD_W-1:0] CMD_Wrapper_unused();
		return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
	endfunction

	initial begin
		int                       k;
		int                       r;
		int                       drain;
		bit                       grow;
		logic [CMD_W-1:0]         c;
		logic signed [DATA_W-1:0] arg;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = bde_pkg::CMD_INS_FRONT;
		operand      = '0;
		hold_request = 1'b0;
		calm         = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty and short list corner cases
		send_cmd(bde_pkg::CMD_DUMP,       0);             // dump of an empty list
		send_cmd(bde_pkg::CMD_RM_FRONT,   0);             // removes on an empty list
		send_cmd(bde_pkg::CMD_RM_BACK,    0);
		send_cmd(bde_pkg::CMD_RM_SECOND,  0);
		send_cmd(bde_pkg::CMD_INS_PENULT, 32'h1234_5678); // too short, nothing happens
		send_cmd(bde_pkg::CMD_INS_BACK,   32'h7fff_ffff);
		send_cmd(bde_pkg::CMD_INS_PENULT, 32'h1234_5678); // still only one entry
		send_cmd(bde_pkg::CMD_INS_FRONT,  32'h8000_0000);
		send_cmd(bde_pkg::CMD_RM_SECOND,  0);             // two entries, front moves up
		send_cmd(bde_pkg::CMD_INS_BACK,   -1);
		send_cmd(bde_pkg::CMD_INS_PENULT, 32'h5555_aaaa);
		send_cmd(bde_pkg::CMD_APPEND_SZ,  0);
		send_cmd(bde_pkg::CMD_DUMP,       0);
		send_cmd(bde_pkg::CMD_RM_LAST_N,  -5);            // negative count removes nothing
		send_cmd(bde_pkg::CMD_RM_LAST_N,  2);
		// fill up past the depth, then every insert flavor on a full list
		send_cmd(bde_pkg::CMD_APPEND_ASC, 40);
		send_cmd(bde_pkg::CMD_INS_FRONT,  32'haaaa_5555);
		send_cmd(bde_pkg::CMD_INS_BACK,   32'haaaa_5555);
		send_cmd(bde_pkg::CMD_INS_PENULT, 32'haaaa_5555);
		send_cmd(bde_pkg::CMD_APPEND_SZ,  0);
		send_cmd(bde_pkg::CMD_APPEND_ASC, 32'h8000_0000); // negative count, no overflow
		send_cmd(bde_pkg::CMD_DUMP,       0);             // full dump
		send_cmd(bde_pkg::CMD_RM_LAST_N,  32'h7fff_ffff); // beyond size, empties the list
		send_cmd(CMD_UNUSED_LO,  -1);
		send_cmd(CMD_UNUSED_HI,  0);

		// random: phases that lean toward growing and toward shrinking
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == HOLD_AT_ITEM)
				hold_request <= 1'b1;
			if (k == RANDOM_ITEMS - CALM_ITEMS)
				calm <= 1'b1;
			grow = ((k / 24) % 2) == 0;
			r = $urandom_range(0, 99);
			// in shrink phases half the plain inserts turn into removes
			if (!grow && r < 30 && $urandom_range(0, 1) == 1)
				r = r + 30;
			arg = pick_word();
			if (r < 14)
				c = bde_pkg::CMD_INS_FRONT;
			else if (r < 30)
				c = bde_pkg::CMD_INS_BACK;
			else if (r < 40)
				c = bde_pkg::CMD_RM_FRONT;
			else if (r < 50)
				c = bde_pkg::CMD_RM_BACK;
			else if (r < 55) begin
				c   = bde_pkg::CMD_RM_LAST_N;
				arg = pick_count();
			end else if (r < 62)
				c = bde_pkg::CMD_RM_SECOND;
			else if (r < 68)
				c = bde_pkg::CMD_APPEND_SZ;
			else if (r < 74) begin
				c   = bde_pkg::CMD_APPEND_ASC;
				arg = pick_count();
			end else if (r < 84)
				c = bde_pkg::CMD_INS_PENULT;
			else if (r < 95)
				c = bde_pkg::CMD_DUMP;
			else
				c = CMD_Wrapper_unused();
			send_cmd(c, arg);
		end
		in_valid <= 1'b0;

		// let the checker see the last beat, then drain the expected results
		repeat (2) @(posedge clk);
		drain = 0;
		while (pending != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		// stray extra beats would show up here
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
